### design/dtt_pkg.sv
`timescale 1ns / 1ps

package dtt_pkg;

  // Table geometry
  localparam int SLOTS   = 16;
  localparam int ID_BITS = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // Fixed port widths
  localparam int CFG_W    = 5;
  localparam int FUNC_W   = 3;
  localparam int TID_W    = 8;
  localparam int TIME_W   = 64;
  localparam int AK_W     = 2;
  localparam int ST_W     = 2;
  localparam int ACTIVE_W = 5;
  localparam int FSLOT_W  = 4;
  localparam int LIM_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_SET_ABS = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET_REL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_TRIGGER = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK    = 3'd4;

  // Action request codes on a set
  localparam logic [AK_W-1:0] AK_KEEP    = 2'd0;
  localparam logic [AK_W-1:0] AK_REPEAT  = 2'd1;
  localparam logic [AK_W-1:0] AK_ONESHOT = 2'd2;
  localparam logic [AK_W-1:0] AK_NONE    = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FAIL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REPEAT  = 2'd1,
    ACT_ONESHOT = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Write command into the slot table
  typedef struct packed {
    logic               set;
    logic               clear;
    logic               inc_used;
    logic               action_we;
    action_t            action;
    logic [SLOT_W-1:0]  idx;
    logic [ID_BITS-1:0] id;
    logic [TIME_W-1:0]  deadline;
  } tbl_wr_t;

  // Read view of one slot
  typedef struct packed {
    logic               valid;
    action_t            action;
    logic [ID_BITS-1:0] id;
    logic [TIME_W-1:0]  deadline;
  } tbl_rd_t;

endpackage

### design/dtt_table.sv
`timescale 1ns / 1ps

module dtt_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dtt_pkg::SLOT_W-1:0] rd_idx,
  output dtt_pkg::tbl_rd_t           rd,
  input  dtt_pkg::tbl_wr_t           wr,
  output logic [dtt_pkg::CNT_W-1:0]  used_count
);
  import dtt_pkg::*;

  logic               slot_valid    [SLOTS];
  action_t            slot_action   [SLOTS];
  logic [ID_BITS-1:0] slot_id       [SLOTS];
  logic [TIME_W-1:0]  slot_deadline [SLOTS];

  // Control state: valid bits, actions, high-water count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i]  <= 1'b0;
        slot_action[i] <= ACT_NONE;
      end
      used_count <= '0;
    end else begin
      if (wr.set) begin
        slot_valid[wr.idx] <= 1'b1;
        if (wr.action_we) begin
          slot_action[wr.idx] <= wr.action;
        end
      end else if (wr.clear) begin
        slot_valid[wr.idx] <= 1'b0;
      end
      if (wr.inc_used) begin
        used_count <= used_count + CNT_W'(1);
      end
    end
  end

  // Payload: written on set only
  always_ff @(posedge clk) begin
    if (wr.set) begin
      slot_id[wr.idx]       <= wr.id;
      slot_deadline[wr.idx] <= wr.deadline;
    end
  end

  always_comb begin
    rd.valid    = slot_valid[rd_idx];
    rd.action   = slot_action[rd_idx];
    rd.id       = slot_id[rd_idx];
    rd.deadline = slot_deadline[rd_idx];
  end

endmodule

### design/dtt_cmp.sv
`timescale 1ns / 1ps

module dtt_cmp (
  input  logic [dtt_pkg::ID_BITS-1:0] key_id,
  input  logic [dtt_pkg::ID_BITS-1:0] slot_id,
  input  logic [dtt_pkg::TIME_W-1:0]  deadline,
  input  logic [dtt_pkg::TIME_W-1:0]  now_time,
  output logic                        id_eq,
  output logic                        due
);
  import dtt_pkg::*;

  // One id match and one deadline compare, shared by every scan step
  assign id_eq = (key_id == slot_id);
  assign due   = (deadline <= now_time);

endmodule

### design/dtt_seq.sv
`timescale 1ns / 1ps

module dtt_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [dtt_pkg::FUNC_W-1:0]   func,
  input  logic [dtt_pkg::TID_W-1:0]    timer_id,
  input  logic [dtt_pkg::TIME_W-1:0]   time_value,
  input  logic [dtt_pkg::TIME_W-1:0]   now_time,
  input  logic [dtt_pkg::AK_W-1:0]     action_kind,
  input  logic [dtt_pkg::LIM_W-1:0]    limit,
  input  logic [dtt_pkg::CNT_W-1:0]    used_count,
  input  dtt_pkg::tbl_rd_t             rd,
  input  logic                         id_eq,
  input  logic                         due,
  output logic [dtt_pkg::SLOT_W-1:0]   rd_idx,
  output dtt_pkg::tbl_wr_t             wr,
  output logic [dtt_pkg::ID_BITS-1:0]  key_id,
  output logic [dtt_pkg::TIME_W-1:0]   key_now,
  output logic                         result_valid,
  output logic                         kind,
  output logic [dtt_pkg::ST_W-1:0]     status,
  output logic [dtt_pkg::ACTIVE_W-1:0] active_count,
  output logic [dtt_pkg::FSLOT_W-1:0]  fired_slot,
  output logic [dtt_pkg::TID_W-1:0]    fired_id,
  output logic [dtt_pkg::TIME_W-1:0]   fire_time,
  output logic                         last
);
  import dtt_pkg::*;

  state_t             state, state_next;
  logic [FUNC_W-1:0]  func_r;
  logic [ID_BITS-1:0] id_r;
  logic [TIME_W-1:0]  dl_r;
  logic [TIME_W-1:0]  now_r;
  logic [AK_W-1:0]    ak_r;
  logic [CNT_W-1:0]   n_r;
  logic [CNT_W-1:0]   idx, idx_next;
  logic               any_r, any_next;
  logic               set_ok_r, set_ok_next;
  logic [ST_W-1:0]    status_r, status_next;
  logic               fire_emit;
  logic               at_end;
  logic               new_slot_ok;
  logic               idx_ok;
  action_t            set_action;
  logic               set_action_we;

  assign busy    = (state != S_IDLE);
  assign rd_idx  = idx[SLOT_W-1:0];
  assign key_id  = id_r;
  assign key_now = now_r;
  assign at_end  = (idx == n_r);
  assign new_slot_ok = (LIM_W'(n_r) < limit);
  // A reused slot must also sit below the current slot limit
  assign idx_ok  = (LIM_W'(idx) < limit);

  always_comb begin
    set_action    = ACT_NONE;
    set_action_we = 1'b1;
    case (ak_r)
      AK_REPEAT:  set_action = ACT_REPEAT;
      AK_ONESHOT: set_action = ACT_ONESHOT;
      AK_NONE:    set_action = ACT_NONE;
      default:    set_action_we = 1'b0;
    endcase
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    any_next     = any_r;
    set_ok_next  = set_ok_r;
    status_next  = status_r;
    fire_emit    = 1'b0;
    wr           = '0;
    wr.idx       = idx[SLOT_W-1:0];
    wr.id        = id_r;
    wr.deadline  = dl_r;
    wr.action    = set_action;
    wr.action_we = set_action_we;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_next = idx + CNT_W'(1);
        unique case (func_r)
          FN_SET_ABS, FN_SET_REL: begin
            if (at_end) begin
              state_next = S_DONE;
              if (new_slot_ok) begin
                wr.set      = 1'b1;
                wr.inc_used = 1'b1;
                set_ok_next = 1'b1;
                status_next = ST_OK;
              end else begin
                status_next = ST_FAIL;
              end
            end else if (!rd.valid || id_eq) begin
              state_next = S_DONE;
              if (idx_ok) begin
                wr.set      = 1'b1;
                set_ok_next = 1'b1;
                status_next = ST_OK;
              end else begin
                status_next = ST_FAIL;
              end
            end
          end
          FN_REMOVE, FN_TRIGGER: begin
            if (at_end) begin
              state_next  = S_DONE;
              status_next = ST_NOT_FOUND;
            end else if (rd.valid && id_eq) begin
              state_next  = S_DONE;
              status_next = ST_OK;
              if (func_r == FN_REMOVE) begin
                wr.clear = 1'b1;
              end else begin
                fire_emit = (rd.action != ACT_NONE);
                wr.clear  = (rd.action == ACT_ONESHOT);
              end
            end
          end
          FN_TICK: begin
            if (at_end) begin
              state_next  = S_DONE;
              status_next = any_r ? ST_OK : ST_FAIL;
            end else if (rd.valid && due) begin
              any_next  = 1'b1;
              fire_emit = (rd.action != ACT_NONE);
              wr.clear  = (rd.action == ACT_ONESHOT);
            end
          end
          default: begin
            state_next  = S_DONE;
            status_next = ST_FAIL;
          end
        endcase
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= fire_emit || (state == S_DONE);
    end
  end

  // Operand capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      if (start) begin
        func_r   <= func;
        id_r     <= timer_id[ID_BITS-1:0];
        dl_r     <= (func == FN_SET_REL) ? time_value + now_time : time_value;
        now_r    <= now_time;
        ak_r     <= action_kind;
        n_r      <= used_count;
        idx      <= '0;
        any_r    <= 1'b0;
        set_ok_r <= 1'b0;
        status_r <= ST_FAIL;
      end
    end else begin
      idx      <= idx_next;
      any_r    <= any_next;
      set_ok_r <= set_ok_next;
      status_r <= status_next;
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (fire_emit) begin
      kind         <= KIND_FIRED;
      status       <= ST_OK;
      active_count <= '0;
      fired_slot   <= FSLOT_W'(idx);
      fired_id     <= TID_W'(rd.id);
      fire_time    <= now_r;
      last         <= 1'b0;
    end else begin
      kind         <= KIND_STATUS;
      status       <= status_r;
      active_count <= set_ok_r ? ACTIVE_W'(used_count) : '0;
      fired_slot   <= '0;
      fired_id     <= '0;
      fire_time    <= '0;
      last         <= 1'b1;
    end
  end

endmodule

### design/deadline_timer_table_unit.sv
`timescale 1ns / 1ps

// Deadline timer table: up to SLOTS timers keyed by id, each with a 64-bit
// deadline and an action (none, repeating, one-shot). Pulse start while busy
// is low to issue one command: set absolute, set relative, remove, force
// trigger or tick. The command runs on a sequencer that walks the used slots
// one per cycle through a single id/deadline compare unit; tick walks them
// all, set stops at the first free or matching slot, and remove and trigger
// stop at the first matching slot. Every result is a one-cycle beat on
// result_valid and cannot be stalled: fired events come out during the scan,
// one per cycle at most, and each command ends with exactly one status beat
// with last high. slots_in_use is written through the cfg channel, which is
// always ready; write it only while busy is low.
module deadline_timer_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [dtt_pkg::FUNC_W-1:0]   func,
  input  logic [dtt_pkg::TID_W-1:0]    timer_id,
  input  logic [dtt_pkg::TIME_W-1:0]   time_value,
  input  logic [dtt_pkg::TIME_W-1:0]   now_time,
  input  logic [dtt_pkg::AK_W-1:0]     action_kind,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dtt_pkg::CFG_W-1:0]    cfg_data,
  output logic                         result_valid,
  output logic                         kind,
  output logic [dtt_pkg::ST_W-1:0]     status,
  output logic [dtt_pkg::ACTIVE_W-1:0] active_count,
  output logic [dtt_pkg::FSLOT_W-1:0]  fired_slot,
  output logic [dtt_pkg::TID_W-1:0]    fired_id,
  output logic [dtt_pkg::TIME_W-1:0]   fire_time,
  output logic                         last
);
  import dtt_pkg::*;

  logic [CFG_W-1:0]   slots_in_use;
  logic [LIM_W-1:0]   limit;
  logic [CNT_W-1:0]   used_count;
  logic [SLOT_W-1:0]  rd_idx;
  tbl_rd_t            rd;
  tbl_wr_t            wr;
  logic [ID_BITS-1:0] key_id;
  logic [TIME_W-1:0]  key_now;
  logic               id_eq;
  logic               due;

  // Config beat: always take it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CFG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use <= cfg_data;
    end
  end

  // Clamp the configured slot count to the table depth
  assign limit = (LIM_W'(slots_in_use) > LIM_W'(SLOTS)) ? LIM_W'(SLOTS)
                                                        : LIM_W'(slots_in_use);

  dtt_table u_table (
    .clk        (clk),
    .rst        (rst),
    .rd_idx     (rd_idx),
    .rd         (rd),
    .wr         (wr),
    .used_count (used_count)
  );

  // Shared compare unit for the scan
  dtt_cmp u_cmp (
    .key_id   (key_id),
    .slot_id  (rd.id),
    .deadline (rd.deadline),
    .now_time (key_now),
    .id_eq    (id_eq),
    .due      (due)
  );

  dtt_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .timer_id     (timer_id),
    .time_value   (time_value),
    .now_time     (now_time),
    .action_kind  (action_kind),
    .limit        (limit),
    .used_count   (used_count),
    .rd           (rd),
    .id_eq        (id_eq),
    .due          (due),
    .rd_idx       (rd_idx),
    .wr           (wr),
    .key_id       (key_id),
    .key_now      (key_now),
    .result_valid (result_valid),
    .kind         (kind),
    .status       (status),
    .active_count (active_count),
    .fired_slot   (fired_slot),
    .fired_id     (fired_id),
    .fire_time    (fire_time),
    .last         (last)
  );

`ifndef NO_ASSERTIONS
  // A command only finishes with its status beat on the outputs
  a_end_with_status: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (result_valid && last))
    else $error("busy dropped without a final status beat");

  // Fired events appear only while a command is running
  a_fire_while_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_FIRED) |-> (busy && !last))
    else $error("fired event outside a running command");

  // The status beat is never followed directly by another beat
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result beat right after a final status beat");
`endif

endmodule
